[src/ifdc_pkg.sv]
// Shared types, constants and helpers for the IR frame deframer.
// No dependencies; every other file in src but ifdc_ram imports this package.
`default_nettype none
package ifdc_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int STORE_DEPTH = MAX_PAYLOAD + 1;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  // largest read cap is 2*MAX_PAYLOAD+5, the count must also hold it
  localparam int CNT_W       = $clog2(2 * MAX_PAYLOAD + 6);
  localparam int LEN_W       = 6;
  localparam int IDX_W       = 2;

  localparam logic [IDX_W-1:0] REG_FAST_MODE = 2'd0;
  localparam logic [IDX_W-1:0] REG_MAX_LEN   = 2'd1;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_NONE = 2'd1;
  localparam logic [1:0] STAT_BAD  = 2'd2;

  localparam logic [7:0] HDR0 = 8'h55;
  localparam logic [7:0] HDR1 = 8'hff;
  localparam logic [7:0] HDR2 = 8'h00;
  localparam logic [7:0] COMPL = 8'hff;

  typedef struct packed {
    logic             fast_mode;
    logic [LEN_W-1:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             header_good;
    logic [7:0]       sum;
    logic             comp_good;
    logic [15:0]      first_two;
    logic [15:0]      last_two;
  } frame_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [LEN_W-1:0] len;
    logic             skip;
  } verdict_t;

  function automatic logic [CNT_W-1:0] read_cap(input cfg_t c);
    logic [LEN_W-1:0] m;
    m = (c.max_len > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : c.max_len;
    if (c.fast_mode) begin
      read_cap = CNT_W'(m) + CNT_W'(4);
    end else begin
      read_cap = (CNT_W'(m) << 1) + CNT_W'(5);
    end
  endfunction

  function automatic logic [7:0] hdr_byte(input logic [1:0] pos);
    case (pos)
      2'd0:    hdr_byte = HDR0;
      2'd1:    hdr_byte = HDR1;
      default: hdr_byte = HDR2;
    endcase
  endfunction

endpackage
`default_nettype wire

[src/ir_frame_deframer_checksum_core.sv]
// Top level of the IR reply-frame deframer: config registers, end-of-frame
// sequencer and output register. Uses ifdc_pkg, ifdc_ram, ifdc_accum, ifdc_judge.
//
// Frame bytes are taken one per cycle while the block is idle; the running
// frame state sits in registers and body bytes go into a 33-entry payload RAM.
// An end marker stalls the input until its whole run is delivered: the
// slow-mode checksum byte is read from the RAM as the marker is taken, the
// frame is judged, then each payload byte is read (the RAM read is registered
// and is issued once per byte) and loaded, then the status word goes out; an
// output stall holds the run. Result words wait in an output register.
`default_nettype none
module ir_frame_deframer_checksum_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_kind,
  input  wire logic [7:0]                   in_rx_byte,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [7:0]                        out_payload_byte,
  output logic [1:0]                        out_status,
  output logic [ifdc_pkg::LEN_W-1:0]        out_payload_length,
  output logic                              out_last,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [ifdc_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [ifdc_pkg::LEN_W-1:0]   cfg_wdata
);
  import ifdc_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_JUDGE   = 3'd1;
  localparam logic [2:0] S_EMIT_RD = 3'd2;
  localparam logic [2:0] S_EMIT_LD = 3'd3;
  localparam logic [2:0] S_STATUS  = 3'd4;

  cfg_t              cfg_r;
  logic [2:0]        state_r, state_nxt;
  verdict_t          verdict, verdict_r, verdict_nxt;
  logic [LEN_W-1:0]  k_r, k_nxt;
  frame_t            frame;
  logic              byte_en, end_en, clear;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;
  logic [CNT_W-1:0]  chk_pos;
  logic [LEN_W-1:0]  emit_idx;
  logic              out_free;

  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;
  logic              out_last_r, out_last_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign byte_en   = in_valid && !in_stall && !in_kind;
  assign end_en    = in_valid && !in_stall && in_kind;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fast_mode <= 1'b0;
      cfg_r.max_len   <= LEN_W'(32);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FAST_MODE: cfg_r.fast_mode <= cfg_wdata[0];
        REG_MAX_LEN:   cfg_r.max_len   <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  ifdc_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .byte_en   (byte_en),
    .rx_byte   (in_rx_byte),
    .clear     (clear),
    .frame     (frame),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  // slow-mode checksum sits at store index (body/2)-1
  assign chk_pos  = ((frame.count - CNT_W'(3)) >> 1) - CNT_W'(1);
  // skip the opcode complement slot after the first payload byte
  assign emit_idx = (verdict_r.skip && k_r != '0) ? k_r + LEN_W'(1) : k_r;

  assign ram_re    = end_en || (state_r == S_EMIT_RD);
  assign ram_raddr = (state_r == S_EMIT_RD) ? emit_idx[ADDR_W-1:0] : chk_pos[ADDR_W-1:0];

  ifdc_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ifdc_judge u_judge (
    .frame   (frame),
    .cfg     (cfg_r),
    .chk     (ram_rdata),
    .verdict (verdict)
  );

  always_comb begin
    state_nxt      = state_r;
    verdict_nxt    = verdict_r;
    k_nxt          = k_r;
    clear          = 1'b0;
    out_valid_nxt  = out_valid_r && out_stall;
    out_byte_nxt   = out_byte_r;
    out_status_nxt = out_status_r;
    out_len_nxt    = out_len_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (end_en) begin
          state_nxt = S_JUDGE;
        end
      end
      S_JUDGE: begin
        verdict_nxt = verdict;
        k_nxt       = '0;
        state_nxt   = (verdict.len != '0) ? S_EMIT_RD : S_STATUS;
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = ram_rdata;
          out_status_nxt = STAT_OK;
          out_len_nxt    = '0;
          out_last_nxt   = 1'b0;
          k_nxt          = k_r + LEN_W'(1);
          state_nxt      = (k_r + LEN_W'(1) == verdict_r.len) ? S_STATUS : S_EMIT_RD;
        end
      end
      S_STATUS: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = 8'h00;
          out_status_nxt = verdict_r.status;
          out_len_nxt    = verdict_r.len;
          out_last_nxt   = 1'b1;
          clear          = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    verdict_r    <= verdict_nxt;
    k_r          <= k_nxt;
    out_byte_r   <= out_byte_nxt;
    out_status_r <= out_status_nxt;
    out_len_r    <= out_len_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_payload_byte   = out_byte_r;
  assign out_status         = out_status_r;
  assign out_payload_length = out_len_r;
  assign out_last           = out_last_r;

  a_end_to_judge: assert property (@(posedge clk) disable iff (!rst_n)
    end_en |=> state_r == S_JUDGE)
    else $error("end marker did not start judgement");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT_RD || state_r == S_EMIT_LD) |-> k_r < verdict_r.len)
    else $error("payload index ran past length");

  a_err_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r && out_status_r != STAT_OK) |-> out_len_r == '0)
    else $error("error status with nonzero length");

  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> out_len_r <= LEN_W'(MAX_PAYLOAD))
    else $error("payload length above maximum");

endmodule
`default_nettype wire

[src/ifdc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ifdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 33
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    // hold read data between reads
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

[src/ifdc_accum.sv]
// Frame accumulator: header check, running sum, complement check and
// payload store writes for each received byte. Uses ifdc_pkg.
`default_nettype none
module ifdc_accum (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ifdc_pkg::cfg_t        cfg,
  input  wire logic                  byte_en,
  input  wire logic [7:0]            rx_byte,
  input  wire logic                  clear,
  output ifdc_pkg::frame_t           frame,
  output logic                       ram_we,
  output logic [ifdc_pkg::ADDR_W-1:0] ram_waddr,
  output logic [7:0]                 ram_wdata
);
  import ifdc_pkg::*;

  frame_t           frame_r, frame_nxt;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] body;
  logic [CNT_W-1:0] idx;
  logic             in_cap;
  logic             keep;

  assign pos    = frame_r.count;
  assign body   = pos - CNT_W'(3);
  assign in_cap = pos < read_cap(cfg);
  // slow mode stores only the uncomplemented bytes
  assign keep   = cfg.fast_mode || !body[0];
  assign idx    = cfg.fast_mode ? body : (body >> 1);

  assign ram_we    = byte_en && in_cap && (pos >= CNT_W'(3)) && keep &&
                     (idx < CNT_W'(STORE_DEPTH));
  assign ram_waddr = idx[ADDR_W-1:0];
  assign ram_wdata = rx_byte;
  assign frame     = frame_r;

  always_comb begin
    frame_nxt = frame_r;
    if (clear) begin
      frame_nxt.count       = '0;
      frame_nxt.header_good = 1'b1;
      frame_nxt.sum         = '0;
      frame_nxt.comp_good   = 1'b1;
      frame_nxt.first_two   = '0;
      frame_nxt.last_two    = '0;
    end else if (byte_en && in_cap) begin
      if (pos < CNT_W'(3)) begin
        if (rx_byte != hdr_byte(pos[1:0])) begin
          frame_nxt.header_good = 1'b0;
        end
      end else begin
        if (keep) begin
          frame_nxt.sum = frame_r.sum + rx_byte;
        end else if ((frame_r.last_two[7:0] ^ rx_byte) != COMPL) begin
          frame_nxt.comp_good = 1'b0;
        end
        if (body == '0) begin
          frame_nxt.first_two = {rx_byte, 8'h00};
        end else if (body == CNT_W'(1)) begin
          frame_nxt.first_two = {frame_r.first_two[15:8], rx_byte};
        end
      end
      frame_nxt.last_two = {frame_r.last_two[7:0], rx_byte};
      frame_nxt.count    = pos + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r.count       <= '0;
      frame_r.header_good <= 1'b1;
      frame_r.sum         <= '0;
      frame_r.comp_good   <= 1'b1;
      frame_r.first_two   <= '0;
      frame_r.last_two    <= '0;
    end else begin
      frame_r <= frame_nxt;
    end
  end

endmodule
`default_nettype wire

[src/ifdc_judge.sv]
// Frame judgement at end of reception: picks the frame layout and gives
// status, payload length and the opcode-complement skip. Uses ifdc_pkg.
`default_nettype none
module ifdc_judge (
  input  wire ifdc_pkg::frame_t frame,
  input  wire ifdc_pkg::cfg_t   cfg,
  input  wire logic [7:0]       chk,
  output ifdc_pkg::verdict_t    verdict
);
  import ifdc_pkg::*;

  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] nb;
  logic [CNT_W-1:0] np;
  logic [7:0]       lastb, prevb, op, opc;
  logic [7:0]       rem1, rem2, rem3, rem_slow;

  assign n     = frame.count;
  assign nb    = n - CNT_W'(3);
  assign np    = nb >> 1;
  assign lastb = frame.last_two[7:0];
  assign prevb = frame.last_two[15:8];
  assign op    = frame.first_two[15:8];
  assign opc   = frame.first_two[7:0];

  // checksum candidates: plain, one trailing extra byte, complemented opcode, slow mode
  assign rem1     = frame.sum - lastb;
  assign rem2     = rem1 - prevb;
  assign rem3     = rem1 - opc;
  assign rem_slow = frame.sum - chk;

  always_comb begin
    verdict.status = STAT_BAD;
    verdict.len    = '0;
    verdict.skip   = 1'b0;
    if (n == '0) begin
      verdict.status = STAT_NONE;
    end else if (n > read_cap(cfg) || !frame.header_good) begin
      verdict.status = STAT_BAD;
    end else if (cfg.fast_mode) begin
      if (n >= CNT_W'(4)) begin
        if (lastb == rem1) begin
          verdict.status = STAT_OK;
          verdict.len    = LEN_W'(nb - CNT_W'(1));
        end else if (nb >= CNT_W'(2) && prevb == rem2) begin
          verdict.status = STAT_OK;
          verdict.len    = LEN_W'(nb - CNT_W'(2));
        end else if (nb >= CNT_W'(3) && (op ^ opc) == COMPL && lastb == rem3) begin
          verdict.status = STAT_OK;
          verdict.len    = LEN_W'(nb - CNT_W'(2));
          verdict.skip   = 1'b1;
        end
      end
    end else begin
      if (n >= CNT_W'(5) && !nb[0] && frame.comp_good && chk == rem_slow) begin
        verdict.status = STAT_OK;
        verdict.len    = LEN_W'(np - CNT_W'(1));
      end
    end
  end

endmodule
`default_nettype wire
